### hdl/bqf_pkg.sv
package bqf_pkg;

  localparam int SampleW    = 24;
  localparam int CoefW      = 32;
  localparam int StateW     = 48;
  localparam int SampleFrac = SampleW - 1;
  localparam int CoefFrac   = CoefW - 6;
  localparam int StateFrac  = StateW - 8;
  localparam int InShift    = StateFrac - SampleFrac;
  localparam int NumCoefs   = 5;
  localparam int CfgIdxW    = 3;

  localparam int HalfW  = StateW / 2;
  localparam int MulAW  = CoefW + 1;
  localparam int MulBW  = HalfW + 1;
  localparam int MulW   = MulAW + MulBW;
  localparam int AccW   = MulAW + StateW;
  localparam int ShW    = AccW - CoefFrac;
  localparam int YqW    = StateW - InShift;
  localparam int RndW   = YqW + 1;

  localparam logic [CfgIdxW-1:0] RegB0 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegB1 = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegB2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegA1 = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegA2 = CfgIdxW'(4);

  typedef logic signed [StateW-1:0]  state_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    logic   ovf;
    state_t val;
  } sat_t;

  localparam state_t StateMax = {1'b0, {(StateW-1){1'b1}}};
  localparam state_t StateMin = {1'b1, {(StateW-1){1'b0}}};
  localparam sample_t SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleW-1){1'b0}}};

  localparam coef_t CoefOne = coef_t'(64'd1 << CoefFrac);

endpackage

### hdl/biquad_iir_filter.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------
// input    | in_valid_i / in_ready_o | sample_in_i
// output   | out_valid_o/out_ready_i | sample_out_o, overflow_o
// config   | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// After acceptance each sample passes the product steps, a feedback step and a
// final step that registers the result; one shared 33 by 25 bit multiplier
// forms each of the five products in two halves. The input is ready only while
// no sample is in work, so a new sample is taken only once the last is done.
// A result waiting in the output register stalls the final step of the next sample.
// Reset clears the delays and loads b0 with one and the other coefficients with zero.
module biquad_iir_filter
  import bqf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SampleW-1:0]  sample_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SampleW-1:0]  sample_out_o,
  output logic                overflow_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CoefW-1:0]    cfg_data_i
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StP0Lo = 4'd1;
  localparam logic [3:0] StP0Hi = 4'd2;
  localparam logic [3:0] StP1Lo = 4'd3;
  localparam logic [3:0] StP1Hi = 4'd4;
  localparam logic [3:0] StP2Lo = 4'd5;
  localparam logic [3:0] StP2Hi = 4'd6;
  localparam logic [3:0] StP3Lo = 4'd7;
  localparam logic [3:0] StP3Hi = 4'd8;
  localparam logic [3:0] StP4Lo = 4'd9;
  localparam logic [3:0] StP4Hi = 4'd10;
  localparam logic [3:0] StFb   = 4'd11;
  localparam logic [3:0] StDone = 4'd12;

  logic [3:0]            step_q, step_d;
  coef_t                 coef_q [NumCoefs];
  state_t                d1_q, d2_q, y_q, t_q, s_q, prod_q;
  sample_t               x_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic                  ovf_q;
  logic                  out_valid_q;
  sample_t               out_sample_q;
  logic                  out_ovf_q;

  logic [CfgIdxW-1:0]    csel;
  logic                  neg_sel, use_y, hi_half, mul_en;
  state_t                opnd, xs;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulW-1:0]  mul_p;
  state_t                add_a, add_b;
  sat_t                  add_r, sh_r;
  logic signed [ShW-1:0] sh;
  logic signed [RndW-1:0] rnd;
  sample_t               q_out;
  logic                  q_ovf;
  logic                  accept, out_free;

  assign in_ready_o   = (step_q == StIdle);
  assign accept       = in_valid_i & in_ready_o;
  assign out_free     = ~out_valid_q | out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign overflow_o   = out_ovf_q;

  assign xs = {{(StateW-SampleW-InShift){x_q[SampleW-1]}}, x_q, {InShift{1'b0}}};

  always_comb begin
    csel    = RegB0;
    neg_sel = 1'b0;
    use_y   = 1'b0;
    hi_half = 1'b0;
    mul_en  = 1'b1;
    unique case (step_q)
      StP0Lo: csel = RegB0;
      StP0Hi: begin
        csel    = RegB0;
        hi_half = 1'b1;
      end
      StP1Lo: csel = RegB1;
      StP1Hi: begin
        csel    = RegB1;
        hi_half = 1'b1;
      end
      StP2Lo: csel = RegB2;
      StP2Hi: begin
        csel    = RegB2;
        hi_half = 1'b1;
      end
      StP3Lo: begin
        csel    = RegA1;
        neg_sel = 1'b1;
        use_y   = 1'b1;
      end
      StP3Hi: begin
        csel    = RegA1;
        neg_sel = 1'b1;
        use_y   = 1'b1;
        hi_half = 1'b1;
      end
      StP4Lo: begin
        csel    = RegA2;
        neg_sel = 1'b1;
        use_y   = 1'b1;
      end
      StP4Hi: begin
        csel    = RegA2;
        neg_sel = 1'b1;
        use_y   = 1'b1;
        hi_half = 1'b1;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    logic signed [MulAW-1:0] c_ext;
    c_ext = {coef_q[csel][CoefW-1], coef_q[csel]};
    mul_a = neg_sel ? -c_ext : c_ext;
    opnd  = use_y ? y_q : xs;
    mul_b = hi_half ? {opnd[StateW-1], opnd[StateW-1:HalfW]}
                    : {1'b0, opnd[HalfW-1:0]};
    mul_p = mul_a * mul_b;
    if (hi_half) begin
      acc_d = acc_q + {mul_p[AccW-HalfW-1:0], {HalfW{1'b0}}};
    end else begin
      acc_d = {{(AccW-MulW){mul_p[MulW-1]}}, mul_p};
    end
  end

  always_comb begin
    sh = acc_q[AccW-1:CoefFrac];
    if ((&sh[ShW-1:StateW-1]) || ~(|sh[ShW-1:StateW-1])) begin
      sh_r.ovf = 1'b0;
      sh_r.val = sh[StateW-1:0];
    end else begin
      sh_r.ovf = 1'b1;
      sh_r.val = sh[ShW-1] ? StateMin : StateMax;
    end
  end

  always_comb begin
    logic signed [StateW:0] sum;
    add_a = prod_q;
    add_b = d1_q;
    case (step_q)
      StP4Hi: begin
        add_a = t_q;
        add_b = prod_q;
      end
      StFb: begin
        add_a = t_q;
        add_b = d2_q;
      end
      StDone: begin
        add_a = s_q;
        add_b = prod_q;
      end
      default: begin
        add_a = prod_q;
        add_b = d1_q;
      end
    endcase
    sum = {add_a[StateW-1], add_a} + {add_b[StateW-1], add_b};
    if (sum[StateW] != sum[StateW-1]) begin
      add_r.ovf = 1'b1;
      add_r.val = sum[StateW] ? StateMin : StateMax;
    end else begin
      add_r.ovf = 1'b0;
      add_r.val = sum[StateW-1:0];
    end
  end

  always_comb begin
    logic signed [YqW-1:0] yq;
    yq  = y_q[StateW-1:InShift];
    rnd = {yq[YqW-1], yq} + RndW'(y_q[InShift-1]);
    if ((&rnd[RndW-1:SampleW-1]) || ~(|rnd[RndW-1:SampleW-1])) begin
      q_ovf = 1'b0;
      q_out = rnd[SampleW-1:0];
    end else begin
      q_ovf = 1'b1;
      q_out = rnd[RndW-1] ? SampleMin : SampleMax;
    end
  end

  always_comb begin
    step_d = step_q;
    unique case (step_q)
      StIdle: if (accept) begin
        step_d = StP0Lo;
      end
      StDone: if (out_free) begin
        step_d = StIdle;
      end
      StP0Lo, StP0Hi, StP1Lo, StP1Hi, StP2Lo, StP2Hi,
      StP3Lo, StP3Hi, StP4Lo, StP4Hi, StFb: step_d = step_q + 4'd1;
      default: step_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StIdle;
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
      coef_q[0]   <= CoefOne;
      for (int i = 1; i < NumCoefs; i++) begin
        coef_q[i] <= '0;
      end
    end else begin
      step_q <= step_d;
      if (out_valid_q && out_ready_i && (step_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_index_i < CfgIdxW'(NumCoefs))) begin
        coef_q[cfg_index_i] <= cfg_data_i;
        d1_q <= '0;
        d2_q <= '0;
      end
      if (accept) begin
        ovf_q <= 1'b0;
      end
      unique case (step_q)
        StP1Lo, StP2Lo, StP3Lo, StP4Lo: ovf_q <= ovf_q | sh_r.ovf;
        StP1Hi, StP4Hi: ovf_q <= ovf_q | add_r.ovf;
        StFb: begin
          ovf_q <= ovf_q | sh_r.ovf | add_r.ovf;
          d1_q  <= add_r.val;
        end
        StDone: if (out_free) begin
          d2_q        <= add_r.val;
          out_valid_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_in_i;
    end
    if (mul_en) begin
      acc_q <= acc_d;
    end
    case (step_q)
      StP1Lo, StP2Lo, StP3Lo, StP4Lo, StFb: prod_q <= sh_r.val;
      default: begin
      end
    endcase
    case (step_q)
      StP1Hi: y_q <= add_r.val;
      StP2Hi: t_q <= prod_q;
      StP3Hi: s_q <= prod_q;
      StP4Hi: t_q <= add_r.val;
      default: begin
      end
    endcase
    if ((step_q == StDone) && out_free) begin
      out_sample_q <= q_out;
      out_ovf_q    <= ovf_q | add_r.ovf | q_ovf;
    end
  end

endmodule

### tb/biquad_checker.sv
module biquad_checker
  import bqf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [SampleW-1:0] sample_in_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [SampleW-1:0] sample_out_i,
  input  logic               overflow_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoefW-1:0]   cfg_data_i,
  output int                 mismatch_count_o,
  output int                 outstanding_o
);

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    sample_t sample;
    logic    ovf;
  } filt_out_t;

  localparam wide_t StMaxW  = wide_t'(StateMax);
  localparam wide_t StMinW  = wide_t'(StateMin);
  localparam wide_t SmpMaxW = wide_t'(SampleMax);
  localparam wide_t SmpMinW = wide_t'(SampleMin);

  filt_out_t expected_q[$];
  coef_t     taps[NumCoefs];
  state_t    z1;
  state_t    z2;
  bit        clip_seen;
  int        mismatches = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = expected_q.size();

  function automatic wide_t clamp_to(input wide_t v, input wide_t lo, input wide_t hi);
    if (v > hi) begin
      clip_seen = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip_seen = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic wide_t tap_product(input coef_t c, input wide_t v, input bit neg);
    wide_t p;
    p = wide_t'(c) * v;
    if (neg) begin
      p = -p;
    end
    return clamp_to(p >>> CoefFrac, StMinW, StMaxW);
  endfunction

  function automatic wide_t sat_add(input wide_t a, input wide_t b);
    return clamp_to(a + b, StMinW, StMaxW);
  endfunction

  function automatic filt_out_t filter_sample(input sample_t x);
    wide_t     xs;
    wide_t     y;
    wide_t     t;
    wide_t     q;
    filt_out_t r;
    clip_seen = 1'b0;
    xs = clamp_to(wide_t'(x) <<< InShift, StMinW, StMaxW);
    y  = sat_add(tap_product(taps[RegB0], xs, 1'b0), wide_t'(z1));
    t  = sat_add(tap_product(taps[RegB1], xs, 1'b0), tap_product(taps[RegA1], y, 1'b1));
    z1 = state_t'(sat_add(t, wide_t'(z2)));
    z2 = state_t'(sat_add(tap_product(taps[RegB2], xs, 1'b0),
                          tap_product(taps[RegA2], y, 1'b1)));
    q  = (y >>> InShift) + ((y >>> (InShift - 1)) & wide_t'(1));
    q  = clamp_to(q, SmpMinW, SmpMaxW);
    r.sample = sample_t'(q);
    r.ovf    = clip_seen;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filt_out_t exp_item;
    if (!rst_ni) begin
      taps[RegB0] = CoefOne;
      taps[RegB1] = '0;
      taps[RegB2] = '0;
      taps[RegA1] = '0;
      taps[RegA2] = '0;
      z1 = '0;
      z2 = '0;
      expected_q.delete();
    end else begin
      if (cfg_we_i && cfg_index_i < NumCoefs) begin
        taps[cfg_index_i] = coef_t'(cfg_data_i);
        z1 = '0;
        z2 = '0;
      end
      // The oldest expectation is taken before a new one is added, since a result
      // can never belong to a transaction accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: expected none, actual %0d/%0b",
                   $time, $signed(sample_out_i), overflow_i);
        end else begin
          exp_item = expected_q.pop_front();
          if (sample_out_i !== exp_item.sample) begin
            mismatches++;
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, $signed(exp_item.sample), $signed(sample_out_i));
          end
          if (overflow_i !== exp_item.ovf) begin
            mismatches++;
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, exp_item.ovf, overflow_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.insert(expected_q.size(), filter_sample(sample_t'(sample_in_i)));
      end
    end
  end

endmodule

### tb/tb_top.sv
module tb_top;
  import bqf_pkg::*;

  localparam int HalfPeriod  = 4;
  localparam int HoldCycles  = 400;
  localparam int IdleLimit   = 3000;
  localparam int NumPhases   = 12;
  localparam int PhaseItems  = 60;
  localparam int SettleDelay = 16;
  localparam int TailDelay   = 40;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [SampleW-1:0] sample_out_o;
  logic               overflow_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoefW-1:0]   cfg_data_i  = '0;

  int mismatch_count;
  int outstanding;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;
  bit stall_free  = 1'b0;
  bit no_gaps     = 1'b0;
  bit ready_lvl   = 1'b0;
  int ready_run   = 0;

  always #HalfPeriod clk_i = ~clk_i;

  biquad_iir_filter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .overflow_o   (overflow_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  biquad_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .sample_in_i      (sample_in_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_out_i     (sample_out_o),
    .overflow_i       (overflow_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("biquad_iir_filter regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random runs of ready and stall, steady ready, or a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (stall_free) begin
        out_ready_i <= 1'b1;
      end else begin
        if (ready_run == 0) begin
          ready_lvl = !ready_lvl;
          if (ready_lvl) begin
            ready_run = $urandom_range(1, 12);
          end else if ($urandom_range(0, 7) == 0) begin
            ready_run = $urandom_range(10, 40);
          end else begin
            ready_run = $urandom_range(1, 6);
          end
        end
        ready_run--;
        out_ready_i <= ready_lvl;
      end
    end
  end

  task automatic push_sample(input sample_t s);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic settle(input int extra);
    idle_sender(1);
    while (outstanding != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_coef(input logic [CfgIdxW-1:0] idx, input coef_t val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_taps(input coef_t b0, input coef_t b1, input coef_t b2,
                           input coef_t a1, input coef_t a2);
    settle(SettleDelay);
    write_coef(RegB0, b0);
    write_coef(RegB1, b1);
    write_coef(RegB2, b2);
    write_coef(RegA1, a1);
    write_coef(RegA2, a2);
  endtask

  function automatic coef_t random_tap(input int shift);
    coef_t tap;
    tap = coef_t'($urandom);
    return tap >>> shift;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s = sample_t'($urandom);
    case ($urandom_range(0, 9))
      0: s = SampleMax;
      1: s = SampleMin;
      2, 3: s = s >>> $urandom_range(8, 20);
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_bursts(input int count);
    int      sent;
    int      burst;
    bit      held;
    sample_t level;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      held  = ($urandom_range(0, 3) == 0);
      level = random_sample();
      for (int k = 0; k < burst && sent < count; k++) begin
        push_sample(held ? level : random_sample());
        sent++;
      end
      if (!no_gaps && $urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 10));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset coefficients give a straight passthrough.
    push_sample(sample_t'(0));
    push_sample(SampleMax);
    push_sample(SampleMin);
    push_sample(sample_t'(1));
    push_sample(sample_t'(-1));
    push_sample(sample_t'(24'h555555));
    push_sample(sample_t'(24'hAAAAAA));
    send_bursts(20);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          load_taps(32'sd4530000, 32'sd9060000, 32'sd4530000,
                    -32'sd76707000, 32'sd27703000);
          repeat (6) push_sample(SampleMax);
          repeat (6) push_sample(SampleMin);
        end
        1: begin
          load_taps(SampleMax == 0 ? '0 : {1'b0, {(CoefW-1){1'b1}}},
                    {1'b0, {(CoefW-1){1'b1}}}, {1'b0, {(CoefW-1){1'b1}}},
                    {1'b0, {(CoefW-1){1'b1}}}, {1'b0, {(CoefW-1){1'b1}}});
          push_sample(sample_t'(0));
          push_sample(SampleMax);
          push_sample(SampleMin);
        end
        2: load_taps({1'b1, {(CoefW-1){1'b0}}}, {1'b1, {(CoefW-1){1'b0}}},
                     {1'b1, {(CoefW-1){1'b0}}}, {1'b1, {(CoefW-1){1'b0}}},
                     {1'b1, {(CoefW-1){1'b0}}});
        3: begin
          load_taps({1'b1, {(CoefW-1){1'b0}}}, '0, '0, '0, '0);
          hold_req = 1'b1;
          for (int k = 0; k < 16; k++) begin
            push_sample(random_sample());
          end
        end
        4: load_taps(32'sd53687091, -32'sd107374182, 32'sd53687091,
                     -32'sd100663296, 32'sd40265318);
        5: load_taps(32'sd335544, '0, -32'sd335544, -32'sd132875551, 32'sd66437775);
        default: begin
          if (ph % 2 == 1) begin
            load_taps(random_tap(0), random_tap(0), random_tap(0),
                      random_tap(0), random_tap(0));
          end else begin
            load_taps(random_tap($urandom_range(3, 8)), random_tap($urandom_range(3, 8)),
                      random_tap($urandom_range(3, 8)), random_tap($urandom_range(3, 8)),
                      random_tap($urandom_range(3, 8)));
          end
        end
      endcase
      stall_free = (ph == 8);
      no_gaps    = (ph == 8);
      send_bursts(PhaseItems / 2);
      // A write to an index beyond the last coefficient must leave the delays alone.
      if (ph == 6 || ph == 10) begin
        settle(SettleDelay);
        write_coef(CfgIdxW'($urandom_range(NumCoefs, (1 << CfgIdxW) - 1)),
                   coef_t'($urandom));
      end
      send_bursts(PhaseItems / 2);
      stall_free = 1'b0;
      no_gaps    = 1'b0;
    end

    settle(TailDelay);
    if (mismatch_count == 0) begin
      $display("biquad_iir_filter regression: pass");
    end else begin
      $display("biquad_iir_filter regression: fail");
    end
    $finish;
  end

endmodule
